>>> hw/rtl/audio_buffer_queue_player_macros.svh
// Assertion helpers for the top-level file, which checks itself.
`ifndef AUDIO_BUFFER_QUEUE_PLAYER_MACROS_SVH
`define AUDIO_BUFFER_QUEUE_PLAYER_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ABQP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, active during reset as well.
`define ABQP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/abqp_pkg.sv
package abqp_pkg;

    // Number of buffers in the ring; free_index is sized for it.
    localparam int QUEUE_DEPTH = 4;
    localparam int QW          = $clog2(QUEUE_DEPTH);

    // Host command codes.
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_COMMIT = 2'd2;

    // Classified operations as they travel to the engine.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_COMMIT = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // How the output stage forms the sample.
    localparam logic [1:0] SK_NONE  = 2'd0;
    localparam logic [1:0] SK_HOLD  = 2'd1;
    localparam logic [1:0] SK_FETCH = 2'd2;

    // Configuration port: register index is paddr[2].
    localparam int         CFG_AW         = 3;
    localparam logic [0:0] REG_SKIP_TICKS = 1'b0;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] write_pos;
        logic [7:0] write_byte;
        logic [8:0] fill_count;
    } t_in_item;

    typedef struct packed {
        logic [9:0]    sample_out;
        logic          starved;
        logic          drop_request;
        logic          queue_full;
        logic [QW-1:0] free_index;
        logic          commit_accepted;
    } t_out_item;

    // Decoded command held in the front queue.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] pos;
        logic [7:0] wbyte;
        logic [8:0] count;
    } t_cmd;

    // Engine result waiting for the output stage.
    typedef struct packed {
        logic [1:0]    kind;
        logic          starved;
        logic          drop;
        logic          full;
        logic [QW-1:0] free_index;
        logic          accepted;
    } t_res;

endpackage

>>> hw/rtl/abqp_front.sv
module abqp_front #(
    parameter int BUFFER_LENGTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  abqp_pkg::t_in_item i_in_item,
    output logic               o_in_stall,
    output logic               o_cmd_valid,
    output abqp_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_ready
);

    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);
    // Largest count that fits both the field and one buffer.
    localparam logic [8:0] SAT = (BUFFER_LENGTH < 512) ? 9'(BUFFER_LENGTH) : 9'd511;

    abqp_pkg::t_cmd     r_q [FQ_DEPTH];
    logic [FQ_AW-1:0]   r_wr;
    logic [FQ_AW-1:0]   r_rd;
    logic [FQ_CW-1:0]   r_count;
    abqp_pkg::t_cmd     w_cmd;
    logic               w_push;
    logic               w_pop;

    // Position modulo the buffer length; the quotient is below 16.
    function automatic logic [7:0] wrap_pos(input logic [7:0] p);
        logic [15:0] v;
        v = {8'd0, p};
        for (int s = 3; s >= 0; s--) begin
            if (v >= (16'(BUFFER_LENGTH) << s)) begin
                v = v - (16'(BUFFER_LENGTH) << s);
            end
        end
        return v[7:0];
    endfunction

    always_comb begin
        unique case (i_in_item.command)
            abqp_pkg::CMD_TICK:   w_cmd.op = abqp_pkg::OP_TICK;
            abqp_pkg::CMD_WRITE:  w_cmd.op = abqp_pkg::OP_WRITE;
            abqp_pkg::CMD_COMMIT: w_cmd.op = abqp_pkg::OP_COMMIT;
            default:              w_cmd.op = abqp_pkg::OP_NOP;
        endcase
        w_cmd.pos   = wrap_pos(i_in_item.write_pos);
        w_cmd.wbyte = i_in_item.write_byte;
        w_cmd.count = (i_in_item.fill_count > SAT) ? SAT : i_in_item.fill_count;
    end

    assign o_in_stall  = (r_count == FQ_CW'(FQ_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd];
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + FQ_AW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + FQ_AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + FQ_CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - FQ_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

endmodule

>>> hw/rtl/abqp_engine.sv
module abqp_engine #(
    parameter int BUFFER_LENGTH = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  abqp_pkg::t_cmd i_cmd,
    output logic           o_cmd_ready,
    input  logic [3:0]     i_skip_ticks,
    input  logic           i_res_taken,
    output logic           o_res_valid,
    output abqp_pkg::t_res o_res,
    output logic [7:0]     o_rdata
);

    localparam int QW    = abqp_pkg::QW;
    localparam int PW    = $clog2(BUFFER_LENGTH);
    localparam int CW    = $clog2(BUFFER_LENGTH + 1);
    localparam int DEPTH = abqp_pkg::QUEUE_DEPTH * BUFFER_LENGTH;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]    r_mem [DEPTH];
    logic [CW-1:0] r_counts [abqp_pkg::QUEUE_DEPTH];

    logic [QW-1:0] r_head, n_head;
    logic [QW-1:0] r_tail, n_tail;
    logic [QW-1:0] r_cur, n_cur;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_rem, n_rem;
    logic [3:0]    r_skip, n_skip;
    logic          r_starved, n_starved;
    logic          r_res_valid;
    abqp_pkg::t_res r_res, n_res;
    logic [7:0]    r_rdata;

    logic          w_fire;
    logic [QW-1:0] w_free;
    logic          w_full;
    logic [QW-1:0] w_next_tail;
    logic          w_queued;
    logic [CW-1:0] w_rem_dec;
    logic [PW-1:0] w_rp_inc;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;
    logic          w_mem_we;
    logic          w_cnt_we;

    function automatic logic [QW-1:0] next_slot(input logic [QW-1:0] k);
        return (k == QW'(abqp_pkg::QUEUE_DEPTH - 1)) ? '0 : k + QW'(1);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [QW-1:0] slot,
                                              input logic [PW-1:0] off);
        return AW'(slot) * AW'(BUFFER_LENGTH) + AW'(off);
    endfunction

    assign o_cmd_ready = !r_res_valid || i_res_taken;
    assign w_fire      = i_cmd_valid && o_cmd_ready;

    assign w_free      = next_slot(r_head);
    assign w_full      = (w_free == r_tail);
    assign w_next_tail = next_slot(r_tail);
    assign w_queued    = (r_tail != r_head);
    assign w_rem_dec   = r_rem - CW'(1);
    assign w_rp_inc    = (r_rp == PW'(BUFFER_LENGTH - 1)) ? '0 : r_rp + PW'(1);
    assign w_rd_addr   = addr_of(r_cur, r_rp);
    assign w_wr_addr   = addr_of(w_free, PW'(i_cmd.pos));

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_cur        = r_cur;
        n_rp         = r_rp;
        n_rem        = r_rem;
        n_skip       = r_skip;
        n_starved    = r_starved;
        w_mem_we     = 1'b0;
        w_cnt_we     = 1'b0;
        n_res        = '0;
        n_res.kind   = abqp_pkg::SK_NONE;

        unique case (i_cmd.op)
            abqp_pkg::OP_TICK: begin
                n_res.kind = abqp_pkg::SK_HOLD;
                if (r_rem != '0) begin
                    if (r_skip == '0) begin
                        n_res.kind = abqp_pkg::SK_FETCH;
                        n_skip     = i_skip_ticks;
                        n_rp       = w_rp_inc;
                        n_rem      = w_rem_dec;
                        if (w_rem_dec == '0) begin
                            if (w_queued) begin
                                n_tail = w_next_tail;
                                n_cur  = w_next_tail;
                                n_rp   = '0;
                                n_rem  = r_counts[w_next_tail];
                            end else begin
                                n_starved  = 1'b1;
                                n_res.drop = 1'b1;
                            end
                        end
                    end else begin
                        n_skip = r_skip - 4'd1;
                    end
                end else if (w_queued) begin
                    // Idle or starved: pick up a waiting buffer.
                    n_tail    = w_next_tail;
                    n_cur     = w_next_tail;
                    n_rp      = '0;
                    n_rem     = r_counts[w_next_tail];
                    n_starved = 1'b0;
                end
            end
            abqp_pkg::OP_WRITE: begin
                w_mem_we = !w_full;
            end
            abqp_pkg::OP_COMMIT: begin
                if (!w_full) begin
                    w_cnt_we       = 1'b1;
                    n_head         = w_free;
                    n_res.accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase

        n_res.starved    = n_starved;
        n_res.free_index = next_slot(n_head);
        n_res.full       = (next_slot(n_head) == n_tail);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_cur       <= '0;
            r_rp        <= '0;
            r_rem       <= '0;
            r_skip      <= '0;
            r_starved   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_cur     <= n_cur;
                r_rp      <= n_rp;
                r_rem     <= n_rem;
                r_skip    <= n_skip;
                r_starved <= n_starved;
            end
            if (w_fire) begin
                r_res_valid <= 1'b1;
            end else if (i_res_taken) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= n_res;
        end
    end

    // Sample store: each item reads the playback byte, and a write item also writes one byte.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            if (w_mem_we) begin
                r_mem[w_wr_addr] <= i_cmd.wbyte;
            end
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_cnt_we) begin
            r_counts[w_free] <= CW'(i_cmd.count);
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_rdata     = r_rdata;

endmodule

>>> hw/rtl/abqp_mix.sv
module abqp_mix (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  abqp_pkg::t_res      i_res,
    input  logic [7:0]          i_rdata,
    output logic                o_res_taken,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output abqp_pkg::t_out_item o_out_item
);

    logic [9:0]  r_held;
    logic [9:0]  w_d;
    logic [10:0] w_sum;
    logic [9:0]  w_sample;

    assign w_d   = {i_rdata, 2'b00};
    assign w_sum = {1'b0, w_d} + {1'b0, r_held};

    always_comb begin
        case (i_res.kind)
            abqp_pkg::SK_FETCH: w_sample = w_sum[10:1];
            abqp_pkg::SK_HOLD:  w_sample = r_held;
            default:            w_sample = '0;
        endcase
    end

    assign o_res_taken = i_res_valid && !i_out_stall;
    assign o_out_valid = i_res_valid;

    always_comb begin
        o_out_item.sample_out      = w_sample;
        o_out_item.starved         = i_res.starved;
        o_out_item.drop_request    = i_res.drop;
        o_out_item.queue_full      = i_res.full;
        o_out_item.free_index      = i_res.free_index;
        o_out_item.commit_accepted = i_res.accepted;
    end

    // The held sample moves only when a fetch result leaves the block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (o_res_taken && i_res.kind == abqp_pkg::SK_FETCH) begin
            r_held <= w_d;
        end
    end

endmodule

>>> hw/rtl/audio_buffer_queue_player.sv
// An accepted item is held in the front queue; its result is registered in the engine and
// offered through the combinational output stage.
// Throughput: one item per cycle while the output does not stall; the sample store takes
// one playback read per item, and a write item also writes one byte.
// Reset (synchronous, active low) clears pointers, counters, flags, the held sample
// and skip_ticks; the sample store and buffer counts are not cleared.
`include "audio_buffer_queue_player_macros.svh"

module audio_buffer_queue_player #(
    parameter int BUFFER_LENGTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  abqp_pkg::t_in_item          i_in_item,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output abqp_pkg::t_out_item         o_out_item,
    input  logic                        i_out_stall,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [abqp_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic           r_skip_ticks;
    logic [3:0]     r_skip;
    logic           w_cmd_valid;
    abqp_pkg::t_cmd w_cmd;
    logic           w_cmd_ready;
    logic           w_res_valid;
    abqp_pkg::t_res w_res;
    logic [7:0]     w_rdata;
    logic           w_res_taken;
    logic           w_cfg_sel;

    assign pready    = 1'b1;
    assign w_cfg_sel = (paddr[2] == abqp_pkg::REG_SKIP_TICKS);
    assign prdata    = w_cfg_sel ? {28'd0, r_skip} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip       <= '0;
            r_skip_ticks <= 1'b0;
        end else if (psel && penable && pwrite && pready && w_cfg_sel) begin
            r_skip       <= pwdata[3:0];
            r_skip_ticks <= 1'b1;
        end
    end

    abqp_front #(
        .BUFFER_LENGTH (BUFFER_LENGTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    abqp_engine #(
        .BUFFER_LENGTH (BUFFER_LENGTH)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_ready  (w_cmd_ready),
        .i_skip_ticks (r_skip),
        .i_res_taken  (w_res_taken),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .o_rdata      (w_rdata)
    );

    abqp_mix u_mix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .i_rdata     (w_rdata),
        .o_res_taken (w_res_taken),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // A drop request only ever comes with the starved level set.
    `ABQP_ASSERT_IMP(a_drop_starved, o_out_valid && o_out_item.drop_request, o_out_item.starved, "drop without starved")
    // Accepted commit results carry no sample and no drop.
    `ABQP_ASSERT_IMP(a_commit_quiet, o_out_valid && o_out_item.commit_accepted, o_out_item.sample_out == 10'd0 && !o_out_item.drop_request, "commit result with sample")
    // The front only holds off the host while it has queued work.
    `ABQP_ASSERT_IMP(a_stall_has_work, o_in_stall, w_cmd_valid, "stall with empty queue")
    // Reset leaves no result pending and the input open.
    `ABQP_ASSERT_NXT(a_reset_clears, !i_rst_n, !o_out_valid && !o_in_stall && !r_skip_ticks, "state survived reset")

endmodule

>>> verif/tb_audio_buffer_queue_player.sv
`timescale 1ns / 100ps

module tb_audio_buffer_queue_player;
    import abqp_pkg::*;

    localparam int BUF_LEN           = 256;
    localparam int RING              = QUEUE_DEPTH;
    localparam int IDLE_LIMIT        = 2000;
    localparam int ITEMS_PER_SETTING = 300;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    t_in_item           i_in_item   = '0;
    logic               i_out_stall = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [CFG_AW-1:0]  paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_item          o_out_item;
    logic [31:0]        prdata;
    logic               pready;

    audio_buffer_queue_player #(
        .BUFFER_LENGTH(BUF_LEN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // Player state as the host sees it.
    logic [7:0]    pcm_mem [RING*BUF_LEN];
    bit            pcm_known [RING*BUF_LEN];
    logic [8:0]    slot_len [RING];
    logic [QW-1:0] head_q;
    logic [QW-1:0] tail_q;
    logic [QW-1:0] play_slot;
    logic [7:0]    rd_pos;
    logic [8:0]    left_n;
    logic [3:0]    skip_left;
    logic [3:0]    skip_ticks_cfg;
    logic [9:0]    held_q;
    logic          starved_q;

    t_in_item  host_items[$];
    t_out_item planned_results[$];
    t_out_item due_results[$];

    bit item_taken;
    bit result_taken;
    bit steady_flow;
    int feed_gap;
    int sink_hold;
    int idle_cycles;
    int n_sent;
    int n_ticks;
    int n_commits;
    int n_refused;
    int n_drops;
    int n_results;
    int n_bad;
    logic [3:0] rand_skip;

    function automatic logic [QW-1:0] next_slot(logic [QW-1:0] k);
        return QW'((k + 1) % RING);
    endfunction

    function automatic bit pick_up_next();
        if (tail_q == head_q) begin
            return 1'b0;
        end
        tail_q    = next_slot(tail_q);
        play_slot = tail_q;
        rd_pos    = '0;
        left_n    = slot_len[tail_q];
        return 1'b1;
    endfunction

    function automatic t_out_item play_step(t_in_item it);
        t_out_item     r;
        logic [QW-1:0] free_s;
        bit            full;
        logic [9:0]    d;
        int            idx;
        r      = '0;
        free_s = next_slot(head_q);
        full   = (free_s == tail_q);
        case (it.command)
            CMD_TICK: begin
                if (left_n != 0) begin
                    if (skip_left == 0) begin
                        skip_left = skip_ticks_cfg;
                        idx       = int'(play_slot) * BUF_LEN + int'(rd_pos);
                        d         = {pcm_mem[idx], 2'b00};
                        rd_pos    = 8'((rd_pos + 1) % BUF_LEN);
                        left_n    = left_n - 1'b1;
                        if (left_n == 0) begin
                            if (!pick_up_next()) begin
                                starved_q      = 1'b1;
                                r.drop_request = 1'b1;
                            end
                        end
                        r.sample_out = 10'((11'(d) + 11'(held_q)) >> 1);
                        held_q       = d;
                    end else begin
                        skip_left    = skip_left - 1'b1;
                        r.sample_out = held_q;
                    end
                end else begin
                    r.sample_out = held_q;
                    if (pick_up_next()) begin
                        starved_q = 1'b0;
                    end
                end
            end
            CMD_WRITE: begin
                if (!full) begin
                    idx            = int'(free_s) * BUF_LEN + int'(it.write_pos);
                    pcm_mem[idx]   = it.write_byte;
                    pcm_known[idx] = 1'b1;
                end
            end
            CMD_COMMIT: begin
                if (!full) begin
                    slot_len[free_s]  = (it.fill_count > BUF_LEN) ? 9'(BUF_LEN) : it.fill_count;
                    head_q            = free_s;
                    r.commit_accepted = 1'b1;
                end
            end
            default: ;
        endcase
        free_s       = next_slot(head_q);
        r.starved    = starved_q;
        r.queue_full = (free_s == tail_q);
        r.free_index = free_s;
        return r;
    endfunction

    // A committed count never reaches past the bytes already written into the
    // free buffer, so playback only reads positions that hold data.
    function automatic logic [8:0] commit_count();
        int base;
        int n;
        if (next_slot(head_q) == tail_q) begin
            return 9'($urandom_range(0, 511));
        end
        base = int'(next_slot(head_q)) * BUF_LEN;
        n    = 0;
        while (n < BUF_LEN && pcm_known[base + n]) begin
            n++;
        end
        if (n == BUF_LEN && $urandom_range(0, 1) == 1) begin
            return 9'($urandom_range(BUF_LEN, 511));
        end
        return 9'($urandom_range(0, n));
    endfunction

    task automatic send(logic [1:0] cmd, logic [7:0] pos, logic [7:0] data, logic [8:0] cnt);
        t_in_item  it;
        t_out_item r;
        it = '{command: cmd, write_pos: pos, write_byte: data, fill_count: cnt};
        r  = play_step(it);
        host_items.push_back(it);
        planned_results.push_back(r);
        n_sent++;
        if (cmd == CMD_TICK) n_ticks++;
        if (r.drop_request) n_drops++;
        if (r.commit_accepted) n_commits++;
        if (cmd == CMD_COMMIT && !r.commit_accepted) n_refused++;
    endtask

    task automatic send_directed();
        send(CMD_TICK, 8'd0, 8'd0, 9'd0);
        // An empty buffer is accepted and then passed over by the next tick.
        send(CMD_COMMIT, 8'd0, 8'd0, 9'd0);
        repeat (2) send(CMD_TICK, 8'd0, 8'd0, 9'd0);
        send(CMD_WRITE, 8'd0, 8'd255, 9'd0);
        send(CMD_WRITE, 8'd1, 8'd0, 9'd0);
        send(CMD_WRITE, 8'd2, 8'h80, 9'd0);
        send(CMD_WRITE, 8'd255, 8'h5a, 9'd0);
        send(CMD_COMMIT, 8'd0, 8'd0, 9'd3);
        // The first tick picks up the buffer; its third fetch, on the fourth tick, empties the ring and sets starved.
        repeat (4) send(CMD_TICK, 8'd0, 8'd0, 9'd0);
        repeat (3) send(CMD_COMMIT, 8'd0, 8'd0, 9'd0);
        send(CMD_COMMIT, 8'hff, 8'hff, 9'h1ff);
        send(CMD_WRITE, 8'd7, 8'haa, 9'd0);
        send(OP_NOP, 8'hff, 8'hff, 9'h1ff);
        repeat (3) send(CMD_TICK, 8'd0, 8'd0, 9'd0);
    endtask

    task automatic send_random(int n);
        int goal;
        int sel;
        int k;
        int p;
        goal = n_sent + n;
        while (n_sent < goal) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                k = ($urandom_range(0, 49) == 0) ? BUF_LEN : $urandom_range(0, 12);
                for (p = 0; p < k; p++) begin
                    send(CMD_WRITE, 8'(p), 8'($urandom), 9'($urandom));
                end
                send(CMD_COMMIT, 8'($urandom), 8'($urandom), commit_count());
            end else if (sel < 80) begin
                repeat ($urandom_range(1, 10)) begin
                    send(CMD_TICK, 8'($urandom), 8'($urandom), 9'($urandom));
                end
            end else begin
                case ($urandom_range(0, 2))
                    0: send(CMD_WRITE, 8'($urandom), 8'($urandom), 9'($urandom));
                    1: send(CMD_COMMIT, 8'($urandom), 8'($urandom), commit_count());
                    default: send(OP_NOP, 8'($urandom), 8'($urandom), 9'($urandom));
                endcase
            end
        end
    endtask

    task automatic set_skip(logic [3:0] v);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {REG_SKIP_TICKS, 2'b00};
        pwdata  = 32'(v);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        skip_ticks_cfg = v;
    endtask

    task automatic wait_drained();
        while (host_items.size() != 0 || planned_results.size() != 0 ||
               due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Host side: items change at the falling edge, one item per draw of the gap.
    always @(negedge i_clk) begin
        logic     nv;
        t_in_item nxt;
        nv  = i_in_valid;
        nxt = i_in_item;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (item_taken) begin
                nv       = 1'b0;
                feed_gap = steady_flow ? 0 : $urandom_range(0, 13);
            end
            if (!nv) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                end else if (host_items.size() != 0) begin
                    nxt = host_items.pop_front();
                    nv  = 1'b1;
                end
            end
        end
        i_in_valid <= nv;
        i_in_item  <= nxt;
        if (result_taken) begin
            sink_hold = steady_flow ? 0 : $urandom_range(0, 13);
        end
        if (sink_hold > 0) begin
            i_out_stall <= 1'b1;
            sink_hold--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        item_taken   = 1'b0;
        result_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                item_taken = 1'b1;
                due_results.push_back(planned_results.pop_front());
            end
            if (o_out_valid && !i_out_stall) begin
                result_taken = 1'b1;
                n_results++;
                if (due_results.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("result %0d arrived with no item waiting for it", n_results);
                    end
                end else begin
                    want = due_results.pop_front();
                    if (o_out_item !== want) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display("result %0d mismatch: expected sample %0d starved %b drop %b %s",
                                     n_results, want.sample_out, want.starved,
                                     want.drop_request, "");
                            $display("    expected full %b free %0d accepted %b",
                                     want.queue_full, want.free_index, want.commit_accepted);
                            $display("    got sample %0d starved %b drop %b full %b free %0d acc %b",
                                     o_out_item.sample_out, o_out_item.starved,
                                     o_out_item.drop_request, o_out_item.queue_full,
                                     o_out_item.free_index, o_out_item.commit_accepted);
                        end
                    end
                end
            end
            if (item_taken || result_taken) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("[audio_buffer_queue_player] ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [3:0] settings [6];
        head_q         = '0;
        tail_q         = '0;
        play_slot      = '0;
        rd_pos         = '0;
        left_n         = '0;
        skip_left      = '0;
        skip_ticks_cfg = '0;
        held_q         = '0;
        starved_q      = 1'b0;
        for (int s = 0; s < RING; s++) slot_len[s] = '0;
        rand_skip = 4'($urandom_range(2, 14));
        settings  = '{4'd0, 4'd15, 4'd3, rand_skip, 4'd1, 4'd0};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) wait_drained();
            set_skip(settings[ph]);
            steady_flow = (ph == 2);
            if (ph == 0) send_directed();
            send_random(ITEMS_PER_SETTING);
        end
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Played %0d host items (%0d codec ticks) with skip settings 0, 15, 3, %0d, 1, 0.",
                 n_sent, n_ticks, rand_skip);
        $display("%0d buffers queued, %0d commits refused, %0d underruns, %0d results checked.",
                 n_commits, n_refused, n_drops, n_results);
        if (n_bad == 0 && due_results.size() == 0) begin
            $display("[audio_buffer_queue_player] OK");
        end else begin
            $display("[audio_buffer_queue_player] ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/abqp_pkg.sv
hw/rtl/abqp_front.sv
hw/rtl/abqp_engine.sv
hw/rtl/abqp_mix.sv
hw/rtl/audio_buffer_queue_player.sv
verif/tb_audio_buffer_queue_player.sv
